@@ rtl/pidaw_pkg.sv @@
package pidaw_pkg;

  // fixed point format
  localparam int FRAC_BITS = 15;
  localparam int SPEED_W   = 24;
  localparam int ERR_W     = SPEED_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int INTEG_W   = 32;
  localparam int GAIN_W    = 16;
  localparam int DRIVE_W   = 17;

  // integral limit divider: (1.0 << FRAC_BITS) / ki, one quotient bit per step
  localparam int QUOT_W  = 2 * FRAC_BITS + 1;
  localparam int CNT_W   = $clog2(QUOT_W);
  localparam int ISUM_W  = INTEG_W + 1;
  localparam int CLAMP_W = (QUOT_W + 1 > ISUM_W) ? QUOT_W + 2 : ISUM_W + 1;

  // shared multiplier and accumulator
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = INTEG_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [DRIVE_W-1:0] drive_t;
  typedef logic [GAIN_W-1:0]         gain_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

  localparam cfg_idx_t REG_GAIN_P = 2'd0;
  localparam cfg_idx_t REG_GAIN_I = 2'd1;
  localparam cfg_idx_t REG_GAIN_D = 2'd2;

  // microcode
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_CLAMP,
    OP_MUL_P,
    OP_MUL_I,
    OP_MUL_D,
    OP_ACC,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_KI_ZERO,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  localparam step_t ST_LOAD     = 4'd0;
  localparam step_t ST_DIV_INIT = 4'd1;
  localparam step_t ST_DIV_STEP = 4'd2;
  localparam step_t ST_CLAMP    = 4'd3;
  localparam step_t ST_MUL_P    = 4'd4;
  localparam step_t ST_MUL_I    = 4'd5;
  localparam step_t ST_MUL_D    = 4'd6;
  localparam step_t ST_ACC      = 4'd7;
  localparam step_t ST_OUT      = 4'd8;
  localparam step_t ST_RETURN   = 4'd9;

  // control store: jump to target when the condition holds, else next step
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    unique case (step)
      ST_LOAD:     w = '{op: OP_LOAD,     cond: COND_NO_INPUT, target: ST_LOAD};
      ST_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_KI_ZERO,  target: ST_CLAMP};
      ST_DIV_STEP: w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: ST_DIV_STEP};
      ST_CLAMP:    w = '{op: OP_CLAMP,    cond: COND_NEVER,    target: ST_LOAD};
      ST_MUL_P:    w = '{op: OP_MUL_P,    cond: COND_NEVER,    target: ST_LOAD};
      ST_MUL_I:    w = '{op: OP_MUL_I,    cond: COND_NEVER,    target: ST_LOAD};
      ST_MUL_D:    w = '{op: OP_MUL_D,    cond: COND_NEVER,    target: ST_LOAD};
      ST_ACC:      w = '{op: OP_ACC,      cond: COND_NEVER,    target: ST_LOAD};
      ST_OUT:      w = '{op: OP_OUT,      cond: COND_OUT_BUSY, target: ST_OUT};
      ST_RETURN:   w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: ST_LOAD};
      default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: ST_LOAD};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/pidaw_if.sv @@
interface pidaw_in_if;
  logic             valid;
  logic             ready;
  pidaw_pkg::speed_t target_speed;
  pidaw_pkg::speed_t measured_speed;

  modport source (output valid, output target_speed, output measured_speed, input ready);
  modport sink   (input valid, input target_speed, input measured_speed, output ready);
endinterface

interface pidaw_out_if;
  logic             valid;
  logic             ready;
  pidaw_pkg::drive_t drive;
  logic             drive_saturated;

  modport source (output valid, output drive, output drive_saturated, input ready);
  modport sink   (input valid, input drive, input drive_saturated, output ready);
endinterface

@@ rtl/pid_speed_antiwindup_q15.sv @@
// channel   dir  payload                                 transaction
// in_ch     in   target_speed[24] s, measured_speed[24] s  valid & ready
// out_ch    out  drive[17] s, drive_saturated[1]         valid & ready
// cfg       in   cfg_index[2], cfg_data[16]              cfg_we
//
// between accepts a Q15 sample runs load, divide init, one bit-serial divide step per
// quotient bit to form the integral limit, clamp, the P, I and D multiplies, accumulate,
// output and return; the divide steps are skipped when ki is zero
// reset is synchronous, active low; clears gains, error history and integral
// a new sample is taken while a result still waits; the sequencer only stalls
// at its output step when the previous result has not been taken
module pid_speed_antiwindup_q15 (
  input  logic                 clk,
  input  logic                 rst_n,
  pidaw_in_if.sink             in_ch,
  pidaw_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  pidaw_pkg::cfg_idx_t  cfg_index,
  input  pidaw_pkg::cfg_data_t cfg_data
);
  import pidaw_pkg::*;

  // gains
  gain_t kp_r, ki_r, kd_r;

  // sequencer
  step_t pc_r, pc_nxt;
  ctrl_t ctrl;
  logic  jump;

  // controller state
  logic signed [ERR_W-1:0]   err_now_r, err_now_nxt;
  logic signed [ERR_W-1:0]   err_before_r, err_before_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [ISUM_W-1:0]  isum_r, isum_nxt;

  // divider
  logic [GAIN_W-1:0] rem_r, rem_nxt;
  logic [QUOT_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [GAIN_W:0]   rem_sh;
  logic              rem_ge;

  // multiply and accumulate
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [DIFF_W-1:0]  err_diff;

  // clamp and output
  logic signed [CLAMP_W-1:0] lim_s, isum_ext, clamped;
  logic signed [ACC_W-1:0]   shifted;
  logic signed [ACC_W-1:0]   one_s;
  drive_t                    drive_r, drive_nxt;
  logic                      sat_r, sat_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic in_fire, out_busy;

  assign ctrl     = ucode(pc_r);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_busy = out_valid_r && !out_ch.ready;

  assign in_ch.ready            = (ctrl.op == OP_LOAD);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive           = drive_r;
  assign out_ch.drive_saturated = sat_r;

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_INPUT: jump = !in_fire;
      COND_KI_ZERO:  jump = (ki_r == '0);
      COND_DIV_MORE: jump = (cnt_r != '0);
      COND_OUT_BUSY: jump = out_busy;
      default:       jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : pc_r + step_t'(1);
  end

  // one restoring divide step; the dividend is a single one at bit 2*FRAC_BITS
  assign rem_sh = {rem_r, (cnt_r == CNT_W'(QUOT_W - 1))};
  assign rem_ge = (rem_sh >= {1'b0, ki_r});

  assign err_diff = DIFF_W'(err_now_r) - DIFF_W'(err_before_r);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      OP_MUL_P: begin
        mul_a = {1'b0, kp_r};
        mul_b = MUL_B_W'(err_now_r);
      end
      OP_MUL_I: begin
        mul_a = {1'b0, ki_r};
        mul_b = MUL_B_W'(integ_r);
      end
      OP_MUL_D: begin
        mul_a = {1'b0, kd_r};
        mul_b = MUL_B_W'(err_diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // anti-windup clamp to +/- limit, then to the signed 32-bit range
  always_comb begin
    lim_s    = CLAMP_W'(quot_r);
    isum_ext = CLAMP_W'(isum_r);
    if (isum_ext > lim_s) begin
      clamped = lim_s;
    end else if (isum_ext < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = isum_ext;
    end
    if (clamped > CLAMP_W'(signed'({1'b0, {(INTEG_W-1){1'b1}}}))) begin
      clamped = CLAMP_W'(signed'({1'b0, {(INTEG_W-1){1'b1}}}));
    end else if (clamped < CLAMP_W'(signed'({1'b1, {(INTEG_W-1){1'b0}}}))) begin
      clamped = CLAMP_W'(signed'({1'b1, {(INTEG_W-1){1'b0}}}));
    end
  end

  // floor shift of the Q30 sum back to Q15, then +/-1.0 limit
  assign shifted = acc_r >>> FRAC_BITS;
  assign one_s   = ACC_W'(1) <<< FRAC_BITS;

  always_comb begin
    err_now_nxt    = err_now_r;
    err_before_nxt = err_before_r;
    integ_nxt      = integ_r;
    isum_nxt       = isum_r;
    rem_nxt        = rem_r;
    quot_nxt       = quot_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    drive_nxt      = drive_r;
    sat_nxt        = sat_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    case (ctrl.op)
      OP_LOAD: begin
        if (in_fire) begin
          err_before_nxt = err_now_r;
          err_now_nxt    = ERR_W'(in_ch.target_speed) - ERR_W'(in_ch.measured_speed);
        end
      end
      OP_DIV_INIT: begin
        isum_nxt = ISUM_W'(integ_r) + ISUM_W'(err_now_r);
        rem_nxt  = '0;
        quot_nxt = '0;
        cnt_nxt  = CNT_W'(QUOT_W - 1);
      end
      OP_DIV_STEP: begin
        rem_nxt  = rem_ge ? GAIN_W'(rem_sh - {1'b0, ki_r}) : rem_sh[GAIN_W-1:0];
        quot_nxt = {quot_r[QUOT_W-2:0], rem_ge};
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
      OP_CLAMP: begin
        // zero integral gain clears the integral and skips the clamp
        integ_nxt = (ki_r == '0) ? '0 : clamped[INTEG_W-1:0];
      end
      OP_MUL_P: begin
        acc_nxt  = '0;
        prod_nxt = mul_a * mul_b;
      end
      OP_MUL_I, OP_MUL_D: begin
        acc_nxt  = acc_r + ACC_W'(prod_r);
        prod_nxt = mul_a * mul_b;
      end
      OP_ACC: begin
        acc_nxt = acc_r + ACC_W'(prod_r);
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          if (shifted > one_s) begin
            drive_nxt = DRIVE_W'(one_s);
            sat_nxt   = 1'b1;
          end else if (shifted < -one_s) begin
            drive_nxt = DRIVE_W'(-one_s);
            sat_nxt   = 1'b1;
          end else begin
            drive_nxt = shifted[DRIVE_W-1:0];
            sat_nxt   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= ST_LOAD;
      out_valid_r  <= 1'b0;
      err_now_r    <= '0;
      err_before_r <= '0;
      integ_r      <= '0;
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
    end else begin
      pc_r         <= pc_nxt;
      out_valid_r  <= out_valid_nxt;
      err_now_r    <= err_now_nxt;
      err_before_r <= err_before_nxt;
      integ_r      <= integ_nxt;
      if (cfg_we) begin
        // writes to an unused index fall through
        case (cfg_index)
          REG_GAIN_P: kp_r <= cfg_data;
          REG_GAIN_I: ki_r <= cfg_data;
          REG_GAIN_D: kd_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    isum_r  <= isum_nxt;
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    cnt_r   <= cnt_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    drive_r <= drive_nxt;
    sat_r   <= sat_nxt;
  end

endmodule

@@ rtl/pidaw_checker.sv @@
module pidaw_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input pidaw_pkg::drive_t drive,
  input logic              drive_saturated
);
  import pidaw_pkg::*;

  localparam drive_t ONE_Q = drive_t'(1) <<< FRAC_BITS;

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // drive never leaves +/-1.0
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (drive <= ONE_Q) && (drive >= -ONE_Q))
    else $error("drive out of range");

  // clipped drive sits exactly on a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && drive_saturated |-> (drive == ONE_Q) || (drive == -ONE_Q))
    else $error("saturation flag without limit value");

  // a sample cannot produce its result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result too early after accept");

endmodule

bind pid_speed_antiwindup_q15 pidaw_checker u_pidaw_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .drive           (out_ch.drive),
  .drive_saturated (out_ch.drive_saturated)
);
